// ===== rtl/core/rcpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpf_pkg
// Shared constants for the RC pulse to packet framer: field widths, pulse
// range limits, frame marker bytes, reset values and the scaling constant.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpf_pkg;

  localparam int unsigned PULSE_W  = 15;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CHAN_N   = 5;
  localparam int unsigned PKT_LEN  = 8;
  localparam int unsigned IDX_W    = $clog2(PKT_LEN);
  localparam int unsigned OFFS_W   = 10;

  localparam logic [PULSE_W-1:0] WIDTH_LOW  = 15'd1000;
  localparam logic [PULSE_W-1:0] WIDTH_HIGH = 15'd2000;

  localparam logic [BYTE_W-1:0] BYTE_START   = 8'hAA;
  localparam logic [BYTE_W-1:0] BYTE_END     = 8'h55;
  localparam logic [BYTE_W-1:0] BYTE_FULL    = 8'd255;
  localparam logic [BYTE_W-1:0] RESET_CENTER = 8'd127;
  localparam logic [BYTE_W-1:0] RESET_KILL   = 8'd210;

  // (w - 1000) * 255 / 1000 == ((w - 1000) * SCALE_MUL) >> SCALE_SHIFT
  // exactly for every offset from 0 to 1000.
  localparam int unsigned        SCALE_SHIFT = 18;
  localparam int unsigned        MUL_W       = 17;
  localparam int unsigned        PROD_W      = OFFS_W + MUL_W;
  localparam logic [MUL_W-1:0]   SCALE_MUL   = 17'd66847;

endpackage

`default_nettype wire

// ===== rtl/core/rcpf_pwm_map.sv =====
// ----------------------------------------------------------------------------
// rcpf_pwm_map
// Map one pulse width in microseconds to a channel byte: clamp below 1000
// and above 2000, scale the span 1000..2000 to 0..255 with truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpf_pwm_map
  import rcpf_pkg::*;
(
  input  wire logic [PULSE_W-1:0] pulse,
  output logic      [BYTE_W-1:0]  chan_byte
);

  logic [PULSE_W-1:0] diff;
  logic [OFFS_W-1:0]  offs;
  logic [PROD_W-1:0]  prod;

  assign diff = pulse - WIDTH_LOW;
  assign offs = diff[OFFS_W-1:0];
  assign prod = PROD_W'(offs) * PROD_W'(SCALE_MUL);

  always_comb begin
    if (pulse < WIDTH_LOW) begin
      chan_byte = '0;
    end else if (pulse > WIDTH_HIGH) begin
      chan_byte = BYTE_FULL;
    end else begin
      chan_byte = prod[SCALE_SHIFT +: BYTE_W];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rc_pulse_to_packet_framer_top.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_to_packet_framer_top
// Flow: an accepted beat is registered in the held-channel register, then
//   loaded into the output shift register, which presents the packet bytes.
// The output serializer sends one byte per cycle while out_tready is high;
//   one more beat waits in the held-channel register meanwhile.
// Reset: rst_n synchronous, active low; channels reset to 127 (kill 210).
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_to_packet_framer_top
  import rcpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata, low bit up: pulse_throttle[14:0], pulse_pitch[29:15],
  // pulse_yaw[44:30], pulse_roll[59:45], pulse_kill[74:60], zero pad [79:75]
  input  wire logic [79:0] in_tdata,

  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata, low bit up: packet_byte[7:0]
  output logic      [7:0]  out_tdata,
  output logic             out_tlast
);

  // Unpack the five pulse widths.
  logic [PULSE_W-1:0] pulse   [CHAN_N];
  logic [BYTE_W-1:0]  mapped  [CHAN_N];

  for (genvar c = 0; c < CHAN_N; c++) begin : g_chan
    assign pulse[c] = in_tdata[c*PULSE_W +: PULSE_W];

    rcpf_pwm_map u_map (
      .pulse     (pulse[c]),
      .chan_byte (mapped[c])
    );
  end

  // Held channel bytes double as the pending-packet register: after an
  // accept they hold exactly the bytes of the packet still to be framed.
  logic [BYTE_W-1:0] held_r   [CHAN_N];
  logic [BYTE_W-1:0] held_nxt [CHAN_N];
  logic              pend_valid_r, pend_valid_nxt;

  // Output serializer: packet shift register and byte index.
  logic [BYTE_W-1:0] shreg_r   [PKT_LEN];
  logic [BYTE_W-1:0] shreg_nxt [PKT_LEN];
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic in_fire, out_fire, last_beat, ser_free, load;
  logic [BYTE_W-1:0] csum;

  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;
  assign last_beat = (idx_r == IDX_W'(PKT_LEN-1));

  // Serializer takes a new packet when empty or when finishing its last byte.
  assign ser_free  = !out_valid_r || (out_fire && last_beat);
  assign load      = pend_valid_r && ser_free;

  // Accept while the pending slot is empty or being drained this cycle.
  assign in_tready = !pend_valid_r || load;

  assign csum = held_r[0] ^ held_r[1] ^ held_r[2] ^ held_r[3] ^ held_r[4];

  always_comb begin
    // Throttle always takes the new byte (missing pulse maps to 0);
    // the other channels keep their value when no pulse was seen.
    held_nxt = held_r;
    if (in_fire) begin
      held_nxt[0] = mapped[0];
      for (int c = 1; c < CHAN_N; c++) begin
        if (pulse[c] != '0) begin
          held_nxt[c] = mapped[c];
        end
      end
    end

    pend_valid_nxt = pend_valid_r;
    if (in_fire) begin
      pend_valid_nxt = 1'b1;
    end else if (load) begin
      pend_valid_nxt = 1'b0;
    end

    shreg_nxt     = shreg_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      // Frame: start, five channels, XOR check, end.
      shreg_nxt[0]  = BYTE_START;
      for (int c = 0; c < CHAN_N; c++) begin
        shreg_nxt[c+1] = held_r[c];
      end
      shreg_nxt[PKT_LEN-2] = csum;
      shreg_nxt[PKT_LEN-1] = BYTE_END;
      idx_nxt       = '0;
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      // Advance one byte.
      for (int i = 0; i < PKT_LEN-1; i++) begin
        shreg_nxt[i] = shreg_r[i+1];
      end
      shreg_nxt[PKT_LEN-1] = '0;
      idx_nxt = idx_r + 1'b1;
      if (last_beat) begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r[0]    <= RESET_CENTER;
      held_r[1]    <= RESET_CENTER;
      held_r[2]    <= RESET_CENTER;
      held_r[3]    <= RESET_CENTER;
      held_r[4]    <= RESET_KILL;
      pend_valid_r <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      pend_valid_r <= pend_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Packet bytes are payload: no reset.
  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = shreg_r[0];
  assign out_tlast  = last_beat;

`ifndef SYNTH
  // A fresh packet always opens with the start marker.
  a_start_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_tvalid && out_tdata == BYTE_START && idx_r == '0))
    else $error("packet did not open with start marker");

  // The last beat of a packet carries the end marker.
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == BYTE_END))
    else $error("last beat is not the end marker");

  // Input stalls only while a packet is pending behind a busy serializer.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (pend_valid_r && out_valid_r))
    else $error("input stalled with free serializer");

  // An accepted beat is pending on the next cycle.
  a_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_valid_r)
    else $error("accepted beat was lost");
`endif

endmodule

`default_nettype wire
